[hdl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pil_pkg.sv]
// Package: operation and status codes, field widths and cell control type.
`default_nettype none
package pil_pkg;

    // Field widths of one request and one response
    localparam int FUNC_W     = 3;
    localparam int POS_W      = 10;
    localparam int ITEM_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // Entries OR-ed together in one read-tree group
    localparam int READ_GROUP = 64;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [FUNC_W-1:0] OP_GET    = 3'd2;
    localparam logic [FUNC_W-1:0] OP_SET    = 3'd3;
    localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic shift_up;    // insert: cells above pos take their lower neighbour
        logic shift_down;  // remove: cells from pos take their upper neighbour
        logic load;        // set: cell at pos takes the new word
    } t_cell_ctl;

endpackage
`default_nettype wire

[hdl/pil_cell.sv]
// One storage cell of the list chain.
`default_nettype none
module pil_cell
    import pil_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX_W      = 10,
    parameter int INDEX      = 0
) (
    input  wire                    i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire  [IDX_W-1:0]       i_pos,
    input  wire  [DATA_WIDTH-1:0]  i_item,
    input  wire  [DATA_WIDTH-1:0]  i_prev,   // neighbour one index lower
    input  wire  [DATA_WIDTH-1:0]  i_next,   // neighbour one index higher
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic [DATA_WIDTH-1:0]  o_tap     // own word when selected, else zero
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  at_pos;
    logic                  above_pos;

    assign at_pos    = (MY_IDX == i_pos);
    assign above_pos = (MY_IDX > i_pos);

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            if (at_pos) begin
                n_data = i_item;
            end else if (above_pos) begin
                n_data = i_prev;
            end
        end else if (i_ctl.shift_down) begin
            if (at_pos || above_pos) begin
                n_data = i_next;
            end
        end else if (i_ctl.load && at_pos) begin
            n_data = i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = at_pos ? r_data : '0;

endmodule
`default_nettype wire

[hdl/positional_insert_remove_list_top.sv]
// Top level: positional insert/remove list built from a chain of cells.
`default_nettype none
// Ordered list of up to CAPACITY words with insert, remove, get, set and clear
// by position. Each entry lives in its own cell; insert shifts every cell above
// the position and remove every cell from the position up, in parallel in the
// cycle the request is taken. A get goes through a two-level OR tree (groups of
// READ_GROUP cells, registered, then a final OR) into the response register. The
// next request is taken once the block is no longer busy and the response
// register is free or being read: one request in flight at a time.
// Exactly one response per request. Positions at or beyond the count (beyond it
// for insert) give a bad-position status and change nothing; insert into a full
// list gives a full status. Clear only resets the count. Codes 5 to 7 are
// no-ops answered with an ok status.
module positional_insert_remove_list_top
    import pil_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // [2:0] func, [12:3] position, [44:13] item, [47:45] zero
    input  wire  [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // [31:0] read_item, [33:32] status, [44:34] entry_count, [45] is_empty,
    // [47:46] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int NGRP  = (CAPACITY + READ_GROUP - 1) / READ_GROUP;
    localparam int RDW   = (DATA_WIDTH > ITEM_W) ? DATA_WIDTH : ITEM_W;

    // request fields
    logic [FUNC_W-1:0]     in_func;
    logic [POS_W-1:0]      in_pos;
    logic [ITEM_W-1:0]     in_item;
    logic                  s_xfer;
    logic [CW-1:0]         pos_c;
    logic [CW-1:0]         cnt_c;
    logic [IDX_W-1:0]      pos_idx;
    logic [DATA_WIDTH-1:0] item_w;

    assign in_func = s_axis_tdata[FUNC_W-1:0];
    assign in_pos  = s_axis_tdata[FUNC_W+POS_W-1:FUNC_W];
    assign in_item = s_axis_tdata[FUNC_W+POS_W+ITEM_W-1:FUNC_W+POS_W];
    assign s_xfer  = s_axis_tvalid && s_axis_tready;

    // control state
    logic                  r_busy;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic                  r_get_ok;
    logic                  n_get_ok;
    logic                  r_m_valid;
    t_cell_ctl             ctl;

    // response payload
    logic [ITEM_W-1:0]     r_read_item;
    logic [STATUS_W-1:0]   r_m_status;
    logic [CNT_W-1:0]      r_m_count;

    assign pos_c   = CW'(in_pos);
    assign cnt_c   = CW'(r_count);
    assign pos_idx = IDX_W'(in_pos);
    assign item_w  = DATA_WIDTH'(in_item);

    // request decode
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_get_ok = 1'b0;
        ctl      = '0;
        unique case (in_func)
            OP_INSERT: begin
                if (pos_c > cnt_c) begin
                    n_status = ST_BADPOS;
                end else if (cnt_c >= CW'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.shift_up = 1'b1;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (pos_c >= cnt_c) begin
                    n_status = ST_BADPOS;
                end else begin
                    ctl.shift_down = 1'b1;
                    n_count        = r_count - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (pos_c >= cnt_c) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_get_ok = 1'b1;
                end
            end
            OP_SET: begin
                if (pos_c >= cnt_c) begin
                    n_status = ST_BADPOS;
                end else begin
                    ctl.load = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!s_xfer) begin
            ctl = '0;
        end
    end

    // chain of cells
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_w;
        logic [DATA_WIDTH-1:0] next_w;
        if (c == 0) begin : g_lo
            assign prev_w = item_w;
        end else begin : g_mid_lo
            assign prev_w = cell_data[c-1];
        end
        if (c == CAPACITY - 1) begin : g_hi
            assign next_w = '0;
        end else begin : g_mid_hi
            assign next_w = cell_data[c+1];
        end
        pil_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (c)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_pos  (pos_idx),
            .i_item (item_w),
            .i_prev (prev_w),
            .i_next (next_w),
            .o_data (cell_data[c]),
            .o_tap  (cell_tap[c])
        );
    end

    // read tree, first level: one registered OR per group of cells
    logic [DATA_WIDTH-1:0] r_grp [NGRP];

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [DATA_WIDTH-1:0] grp_or;
        always_comb begin
            grp_or = '0;
            for (int k = 0; k < READ_GROUP; k++) begin
                if (g * READ_GROUP + k < CAPACITY) begin
                    grp_or = grp_or | cell_tap[g * READ_GROUP + k];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (s_xfer) begin
                r_grp[g] <= grp_or;
            end
        end
    end

    // second level: final OR over the groups
    logic [DATA_WIDTH-1:0] rd_or;
    logic [RDW-1:0]        rd_ext;

    always_comb begin
        rd_or = '0;
        for (int g = 0; g < NGRP; g++) begin
            rd_or = rd_or | r_grp[g];
        end
    end
    assign rd_ext = RDW'(rd_or);

    // one request in flight; response register frees the next transfer
    assign s_axis_tready = !r_busy && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_busy  <= 1'b1;
                r_count <= n_count;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
            if (r_busy) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_status <= n_status;
            r_get_ok <= n_get_ok;
        end
        if (r_busy) begin
            r_read_item <= r_get_ok ? rd_ext[ITEM_W-1:0] : '0;
            r_m_status  <= r_status;
            r_m_count   <= r_count;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {
        2'b00,
        (r_m_count == '0),
        COUNT_W'(r_m_count),
        r_m_status,
        r_read_item
    };

endmodule
`default_nettype wire

[hdl/pil_checker.sv]
// Port-level checker for the list top level, with its bind.
`default_nettype none
`include "assert_macros.svh"
module pil_checker
    import pil_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 s_axis_tvalid,
    input wire                 s_axis_tready,
    input wire [S_TDATA_W-1:0] s_axis_tdata,
    input wire                 m_axis_tvalid,
    input wire                 m_axis_tready,
    input wire [M_TDATA_W-1:0] m_axis_tdata
);

    logic                s_xfer;
    logic                m_stall;
    logic [STATUS_W-1:0] m_status;
    logic [COUNT_W-1:0]  m_count;
    logic                m_empty;
    logic                m_bad;

    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign m_stall  = m_axis_tvalid && !m_axis_tready;
    assign m_status = m_axis_tdata[ITEM_W+STATUS_W-1:ITEM_W];
    assign m_count  = m_axis_tdata[ITEM_W+STATUS_W+COUNT_W-1:ITEM_W+STATUS_W];
    assign m_empty  = m_axis_tdata[ITEM_W+STATUS_W+COUNT_W];
    assign m_bad    = (s_axis_tdata[0] == 1'b1) && (m_status == ST_FULL);

    // a stalled response holds
    `PIL_ASSERT_NEXT(a_resp_hold, i_clk, i_rst_n, m_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled response changed")
    // one request at a time: a taken request blocks the next transfer
    `PIL_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_xfer, !s_axis_tready, "request taken while busy")
    // no new request while the response waits
    `PIL_ASSERT_NOW(a_no_take_on_stall, i_clk, i_rst_n, m_stall, !s_axis_tready, "request taken over waiting response")
    // empty flag agrees with the count
    `PIL_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, m_axis_tvalid, m_empty == (m_count == '0), "empty flag disagrees with count")
    // status is one of the defined codes, and full never reports an empty list
    `PIL_ASSERT_NOW(a_status_code, i_clk, i_rst_n, m_axis_tvalid, (m_status == ST_OK || m_status == ST_BADPOS || m_status == ST_FULL) && !(m_status == ST_FULL && m_empty) && !(m_bad && !m_axis_tvalid), "bad status code")

endmodule

bind positional_insert_remove_list_top pil_checker u_pil_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[tb/tb_positional_insert_remove_list_top.sv]
// Testbench: positional list checked transfer by transfer against a mirror list.
`timescale 1ns / 100ps

module tb_positional_insert_remove_list_top;
    import pil_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int POS_MAX      = (1 << POS_W) - 1;
    localparam int MIX_ITEMS    = 300;
    localparam int STEADY_ITEMS = 200;
    localparam int FULL_ITEMS   = 60;
    localparam int OPEN_ITEMS   = 150;
    localparam int DIR_ROWS     = 25;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;
    // Slowest legal run: ~2000 requests, each behind the longest sender gap, its pass
    // through the block and the longest receiver stall, stays well under this limit.
    localparam int CYCLE_LIMIT  = 1_000_000;

    // Codes 5 to 7 have no operation behind them
    localparam logic [FUNC_W-1:0] OP_UNUSED_A = 3'd5;
    localparam logic [FUNC_W-1:0] OP_UNUSED_B = 3'd6;
    localparam logic [FUNC_W-1:0] OP_UNUSED_C = 3'd7;

    // Request as it sits in the low bits of s_axis_tdata
    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic [POS_W-1:0]  pos;
        logic [FUNC_W-1:0] func;
    } t_list_req;

    // Response as it sits in the low bits of m_axis_tdata
    typedef struct packed {
        logic                empty;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic [ITEM_W-1:0]   rd;
    } t_list_resp;

    // One row of the directed table; the response is typed in where chk is set
    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [POS_W-1:0]    pos;
        logic [ITEM_W-1:0]   item;
        logic                chk;
        logic [ITEM_W-1:0]   rd;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } t_dir_row;

    typedef enum int {PH_MIX, PH_FILL, PH_FULL} t_phase;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [2:0] func, [12:3] position, [44:13] item, [47:45] zero
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [31:0] read_item, [33:32] status, [44:34] entry_count, [45] is_empty, [47:46] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;

    positional_insert_remove_list_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Mirror of the list: what the block should hold after every accepted request
    logic [ITEM_W-1:0] mirror [LIST_CAP];
    int                mirror_count = 0;
    int                mirror_peak = 0;

    t_list_resp awaited_resp [$];
    t_dir_row   directed_rows [DIR_ROWS];

    int mismatch_count = 0;
    int resp_seen = 0;
    int req_sent = 0;
    int cycle_count = 0;
    int op_tally [8];
    int status_tally [4];
    bit steady_flow = 1'b0;
    int rx_hold = 0;
    int rx_run = 0;

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long
    function automatic int flow_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Applies one request to the mirror list and returns the response it gives
    function automatic t_list_resp list_apply(input t_list_req r);
        t_list_resp o;
        int p;
        o = '0;
        p = int'(r.pos);
        case (r.func)
            OP_INSERT: begin
                if (p > mirror_count) begin
                    o.status = ST_BADPOS;
                end else if (mirror_count >= LIST_CAP) begin
                    o.status = ST_FULL;
                end else begin
                    for (int i = mirror_count; i > p; i--)
                        mirror[i] = mirror[i - 1];
                    mirror[p] = r.item;
                    mirror_count++;
                end
            end
            OP_REMOVE: begin
                if (p >= mirror_count) begin
                    o.status = ST_BADPOS;
                end else begin
                    for (int i = p; i + 1 < mirror_count; i++)
                        mirror[i] = mirror[i + 1];
                    mirror_count--;
                end
            end
            OP_GET: begin
                if (p >= mirror_count)
                    o.status = ST_BADPOS;
                else
                    o.rd = mirror[p];
            end
            OP_SET: begin
                if (p >= mirror_count)
                    o.status = ST_BADPOS;
                else
                    mirror[p] = r.item;
            end
            OP_CLEAR: begin
                mirror_count = 0;
            end
            default: ;
        endcase
        o.count = COUNT_W'(mirror_count);
        o.empty = (mirror_count == 0);
        return o;
    endfunction

    // Position for an operation: mostly valid (ends favoured), else anywhere
    function automatic logic [POS_W-1:0] pick_pos(input logic [FUNC_W-1:0] f,
                                                  input int in_pct);
        int lim;
        lim = (f == OP_INSERT) ? mirror_count : mirror_count - 1;
        if (lim > POS_MAX)
            lim = POS_MAX;
        if (lim >= 0 && $urandom_range(0, 99) < in_pct) begin
            case ($urandom_range(0, 7))
                0: return '0;
                1: return POS_W'(lim);
                default: return POS_W'($urandom_range(0, lim));
            endcase
        end
        // just past the end, or anywhere in the field
        if (lim < POS_MAX && $urandom_range(0, 3) == 0)
            return POS_W'(lim + 1);
        return POS_W'($urandom_range(0, POS_MAX));
    endfunction

    function automatic t_list_req random_request(input t_phase ph);
        t_list_req r;
        int roll;
        int in_pct;
        roll = $urandom_range(0, 99);
        in_pct = 80;
        case (ph)
            PH_FILL: begin
                in_pct = 97;
                if (roll < 88)      r.func = OP_INSERT;
                else if (roll < 94) r.func = OP_GET;
                else if (roll < 98) r.func = OP_SET;
                else                r.func = OP_REMOVE;
            end
            PH_FULL: begin
                in_pct = 95;
                if (roll < 35)      r.func = OP_INSERT;
                else if (roll < 60) r.func = OP_GET;
                else if (roll < 75) r.func = OP_SET;
                else if (roll < 95) r.func = OP_REMOVE;
                else                r.func = OP_UNUSED_A;
            end
            default: begin
                if (roll < 30)      r.func = OP_INSERT;
                else if (roll < 55) r.func = OP_REMOVE;
                else if (roll < 75) r.func = OP_GET;
                else if (roll < 87) r.func = OP_SET;
                else if (roll < 90) r.func = OP_CLEAR;
                else if (roll < 94) r.func = OP_UNUSED_A;
                else if (roll < 97) r.func = OP_UNUSED_B;
                else                r.func = OP_UNUSED_C;
            end
        endcase
        r.pos = pick_pos(r.func, in_pct);
        r.item = $urandom();
        return r;
    endfunction

    // Drives one request after a random gap and waits for its transfer. valid
    // stays high into the next request when that one comes with no gap.
    task automatic push_request(input t_list_req r, input bit typed,
                                input t_list_resp typed_want);
        int gap;
        t_list_resp want;
        gap = flow_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(r);
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        want = list_apply(r);
        awaited_resp.push_back(typed ? typed_want : want);
        req_sent++;
        op_tally[r.func]++;
        status_tally[want.status]++;
        if (mirror_count > mirror_peak)
            mirror_peak = mirror_count;
    endtask

    task automatic log_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on response %0d, %s: expected 'h%0h, got 'h%0h",
                     resp_seen, what, want, got);
    endtask

    // Receiver: runs of ready broken by stalls of random length
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_run > 0) begin
                rx_run--;
            end else begin
                rx_hold = flow_gap();
                rx_run  = steady_flow ? 0 : $urandom_range(0, 6);
            end
        end
    end

    // Response check, field by field against the oldest awaited response
    always @(posedge i_clk) begin
        t_list_resp got;
        t_list_resp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_list_resp)-1:0];
            if (awaited_resp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("response %0d arrived with nothing awaited: 'h%0h",
                             resp_seen, got);
            end else begin
                want = awaited_resp.pop_front();
                if (got.rd !== want.rd)
                    log_mismatch("read_item", 64'(want.rd), 64'(got.rd));
                if (got.status !== want.status)
                    log_mismatch("status", 64'(want.status), 64'(got.status));
                if (got.count !== want.count)
                    log_mismatch("entry_count", 64'(want.count), 64'(got.count));
                if (got.empty !== want.empty)
                    log_mismatch("is_empty", 64'(want.empty), 64'(got.empty));
            end
            resp_seen++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d responses outstanding",
                     awaited_resp.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_list_req  r;
        t_list_resp w;

        // Empty list, the ends of the list, the field extremes, unused codes,
        // clear leaving stale words behind
        directed_rows = '{
            '{OP_GET,      10'd0,   32'h0,        1'b1, 32'h0, ST_BADPOS, 11'd0, 1'b1},
            '{OP_REMOVE,   10'd0,   32'h0,        1'b1, 32'h0, ST_BADPOS, 11'd0, 1'b1},
            '{OP_SET,      10'd0,   32'hDEADBEEF, 1'b1, 32'h0, ST_BADPOS, 11'd0, 1'b1},
            '{OP_INSERT,   10'd1,   32'h11111111, 1'b1, 32'h0, ST_BADPOS, 11'd0, 1'b1},
            '{OP_INSERT,   POS_W'(POS_MAX), 32'hFFFFFFFF, 1'b1, 32'h0, ST_BADPOS, 11'd0, 1'b1},
            '{OP_INSERT,   10'd0,   32'hFFFFFFFF, 1'b1, 32'h0, ST_OK,     11'd1, 1'b0},
            '{OP_INSERT,   10'd0,   32'h00000000, 1'b0, 32'h0, ST_OK,     11'd2, 1'b0},
            '{OP_INSERT,   10'd2,   32'hA5A5A5A5, 1'b0, 32'h0, ST_OK,     11'd3, 1'b0},
            '{OP_INSERT,   10'd1,   32'h5A5A5A5A, 1'b0, 32'h0, ST_OK,     11'd4, 1'b0},
            '{OP_GET,      10'd0,   32'h0,        1'b0, 32'h0, ST_OK,     11'd4, 1'b0},
            '{OP_GET,      10'd1,   32'h0,        1'b0, 32'h5A5A5A5A, ST_OK, 11'd4, 1'b0},
            '{OP_GET,      10'd3,   32'h0,        1'b0, 32'hA5A5A5A5, ST_OK, 11'd4, 1'b0},
            '{OP_GET,      10'd4,   32'h0,        1'b1, 32'h0, ST_BADPOS, 11'd4, 1'b0},
            '{OP_SET,      10'd2,   32'h12345678, 1'b0, 32'h0, ST_OK,     11'd4, 1'b0},
            '{OP_GET,      10'd2,   32'h0,        1'b0, 32'h12345678, ST_OK, 11'd4, 1'b0},
            '{OP_REMOVE,   10'd1,   32'h0,        1'b0, 32'h0, ST_OK,     11'd0, 1'b0},
            '{OP_GET,      10'd1,   32'h0,        1'b0, 32'h0, ST_OK,     11'd0, 1'b0},
            '{OP_REMOVE,   10'd3,   32'h0,        1'b0, 32'h0, ST_OK,     11'd0, 1'b0},
            '{OP_UNUSED_A, 10'd0,   32'hFFFFFFFF, 1'b0, 32'h0, ST_OK,     11'd0, 1'b0},
            '{OP_UNUSED_B, POS_W'(POS_MAX), 32'h0, 1'b0, 32'h0, ST_OK,    11'd0, 1'b0},
            '{OP_UNUSED_C, 10'd512, 32'h55AA55AA, 1'b0, 32'h0, ST_OK,     11'd0, 1'b0},
            '{OP_CLEAR,    10'd0,   32'h0,        1'b1, 32'h0, ST_OK,     11'd0, 1'b1},
            '{OP_GET,      10'd0,   32'h0,        1'b1, 32'h0, ST_BADPOS, 11'd0, 1'b1},
            '{OP_INSERT,   10'd0,   32'h80000001, 1'b0, 32'h0, ST_OK,     11'd0, 1'b0},
            '{OP_REMOVE,   10'd0,   32'h0,        1'b0, 32'h0, ST_OK,     11'd0, 1'b0}
        };
        foreach (op_tally[k])
            op_tally[k] = 0;
        foreach (status_tally[k])
            status_tally[k] = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            r.func   = directed_rows[k].func;
            r.pos    = directed_rows[k].pos;
            r.item   = directed_rows[k].item;
            w.rd     = directed_rows[k].rd;
            w.status = directed_rows[k].status;
            w.count  = directed_rows[k].count;
            w.empty  = directed_rows[k].empty;
            push_request(r, directed_rows[k].chk, w);
        end

        // Short lists with frequent clears
        for (int n = 0; n < MIX_ITEMS; n++)
            push_request(random_request(PH_MIX), 1'b0, '0);

        // Fill to capacity; the first stretch runs without any idling
        steady_flow = 1'b1;
        for (int n = 0; mirror_count < LIST_CAP; n++) begin
            if (n == STEADY_ITEMS)
                steady_flow = 1'b0;
            push_request(random_request(PH_FILL), 1'b0, '0);
        end
        steady_flow = 1'b0;

        // Around the full mark: full rejects, top entry, shifts across the store
        for (int n = 0; n < FULL_ITEMS; n++)
            push_request(random_request(PH_FULL), 1'b0, '0);

        r.func = OP_CLEAR;
        r.pos  = POS_W'($urandom_range(0, POS_MAX));
        r.item = $urandom();
        push_request(r, 1'b0, '0);

        for (int n = 0; n < OPEN_ITEMS; n++)
            push_request(random_request(PH_MIX), 1'b0, '0);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (awaited_resp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d insert, %0d remove, %0d get, %0d set, %0d clear, %0d unused",
                 req_sent, op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_GET],
                 op_tally[OP_SET], op_tally[OP_CLEAR],
                 op_tally[OP_UNUSED_A] + op_tally[OP_UNUSED_B] + op_tally[OP_UNUSED_C]);
        $display("%0d bad-position and %0d full rejects, list peaked at %0d, %0d mismatches",
                 status_tally[ST_BADPOS], status_tally[ST_FULL], mirror_peak,
                 mismatch_count);
        if (mismatch_count == 0 && awaited_resp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/pil_pkg.sv
hdl/pil_cell.sv
hdl/positional_insert_remove_list_top.sv
hdl/pil_checker.sv
tb/tb_positional_insert_remove_list_top.sv
